// ===== rtl/hwci_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hwci_pkg
// Shared widths, color-select codes, hue window bounds and the hue bundle
// passed from the hue stage to the window stage.
// ----------------------------------------------------------------------------
package hwci_pkg;

	localparam int CHAN_W = 8;
	localparam int SEL_W  = 3;
	// Scaled hue H = hue * d is at most 360 * 255, which fits in 17 bits.
	localparam int HUE_W  = 17;
	// Hue bounds in degrees fit in 9 bits.
	localparam int DEG_W  = 9;

	localparam logic [SEL_W-1:0] SEL_RED    = 3'd1;
	localparam logic [SEL_W-1:0] SEL_YELLOW = 3'd2;
	localparam logic [SEL_W-1:0] SEL_ORANGE = 3'd3;
	localparam logic [SEL_W-1:0] SEL_GREEN  = 3'd4;
	localparam logic [SEL_W-1:0] SEL_BLUE   = 3'd5;

	localparam logic [SEL_W-1:0] SEL_RESET  = SEL_RED;

	localparam logic [DEG_W-1:0] DEG_20  = 9'd20;
	localparam logic [DEG_W-1:0] DEG_50  = 9'd50;
	localparam logic [DEG_W-1:0] DEG_60  = 9'd60;
	localparam logic [DEG_W-1:0] DEG_70  = 9'd70;
	localparam logic [DEG_W-1:0] DEG_120 = 9'd120;
	localparam logic [DEG_W-1:0] DEG_160 = 9'd160;
	localparam logic [DEG_W-1:0] DEG_230 = 9'd230;
	localparam logic [DEG_W-1:0] DEG_240 = 9'd240;
	localparam logic [DEG_W-1:0] DEG_340 = 9'd340;
	localparam logic [DEG_W-1:0] DEG_360 = 9'd360;

	// Scaled hue, its scale d (forced to 1 for a grey pixel) and max channel.
	typedef struct packed {
		logic [HUE_W-1:0]  h;
		logic [CHAN_W-1:0] d;
		logic [CHAN_W-1:0] mx;
	} hue_t;

endpackage

// ===== rtl/hwci_hue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hwci_hue
// Finds max, min and chroma of one pixel and forms the hue scaled by chroma.
// ----------------------------------------------------------------------------
module hwci_hue (
	input  logic [hwci_pkg::CHAN_W-1:0] red,
	input  logic [hwci_pkg::CHAN_W-1:0] green,
	input  logic [hwci_pkg::CHAN_W-1:0] blue,
	output hwci_pkg::hue_t              hue
);

	localparam int ACC_W = hwci_pkg::HUE_W + 1;

	logic [hwci_pkg::CHAN_W-1:0] mx;
	logic [hwci_pkg::CHAN_W-1:0] mn;
	logic [hwci_pkg::CHAN_W-1:0] d;
	logic [hwci_pkg::CHAN_W-1:0] pa;
	logic [hwci_pkg::CHAN_W-1:0] pb;
	logic signed [ACC_W-1:0]     diff;
	logic signed [ACC_W-1:0]     dsx;
	logic signed [ACC_W-1:0]     offs;
	logic signed [ACC_W-1:0]     acc;

	always_comb begin
		mx = red;
		if (green > mx) mx = green;
		if (blue > mx) mx = blue;
		mn = red;
		if (green < mn) mn = green;
		if (blue < mn) mn = blue;
		d = mx - mn;
	end

	// Pick the channel pair and the sector offset; ties go to red, then green.
	always_comb begin
		priority if (mx == red) begin
			pa   = green;
			pb   = blue;
			offs = '0;
		end else if (mx == green) begin
			pa   = blue;
			pb   = red;
			offs = $signed(ACC_W'(hwci_pkg::DEG_120));
		end else begin
			pa   = red;
			pb   = green;
			offs = $signed(ACC_W'(hwci_pkg::DEG_240));
		end
	end

	always_comb begin
		diff = $signed(ACC_W'(pa)) - $signed(ACC_W'(pb));
		dsx  = $signed(ACC_W'(d));
		acc  = diff * $signed(ACC_W'(hwci_pkg::DEG_60)) + offs * dsx;
		// Only the red sector can go negative; wrap it by a full turn.
		if (acc < 0) acc = acc + $signed(ACC_W'(hwci_pkg::DEG_360)) * dsx;
	end

	always_comb begin
		hue.mx = mx;
		if (d == '0) begin
			hue.h = '0;
			hue.d = hwci_pkg::CHAN_W'(1);
		end else begin
			hue.h = acc[hwci_pkg::HUE_W-1:0];
			hue.d = d;
		end
	end

endmodule

// ===== rtl/hwci_window.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hwci_window
// Tests the scaled hue against the selected window and forms the output pixel.
// ----------------------------------------------------------------------------
module hwci_window (
	input  logic [hwci_pkg::SEL_W-1:0]  color_select,
	input  hwci_pkg::hue_t              hue,
	input  logic [hwci_pkg::CHAN_W-1:0] red,
	input  logic [hwci_pkg::CHAN_W-1:0] green,
	input  logic [hwci_pkg::CHAN_W-1:0] blue,
	output logic [hwci_pkg::CHAN_W-1:0] red_out,
	output logic [hwci_pkg::CHAN_W-1:0] green_out,
	output logic [hwci_pkg::CHAN_W-1:0] blue_out,
	output logic                        kept
);

	// Bound T in degrees, scaled by chroma: T * d.
	function automatic logic [hwci_pkg::HUE_W-1:0] scale(
		input logic [hwci_pkg::DEG_W-1:0]  t,
		input logic [hwci_pkg::CHAN_W-1:0] d
	);
		scale = hwci_pkg::HUE_W'(t) * hwci_pkg::HUE_W'(d);
	endfunction

	logic keep;
	logic valid_sel;

	always_comb begin
		keep      = 1'b0;
		valid_sel = 1'b1;
		unique case (color_select)
			hwci_pkg::SEL_RED: begin
				keep = (hue.h <= scale(hwci_pkg::DEG_20, hue.d)) ||
					(hue.h >= scale(hwci_pkg::DEG_340, hue.d));
			end
			hwci_pkg::SEL_YELLOW: begin
				keep = (hue.h >= scale(hwci_pkg::DEG_50, hue.d)) &&
					(hue.h <= scale(hwci_pkg::DEG_70, hue.d));
			end
			hwci_pkg::SEL_ORANGE: begin
				keep = (hue.h >= scale(hwci_pkg::DEG_20, hue.d)) &&
					(hue.h <= scale(hwci_pkg::DEG_50, hue.d));
			end
			hwci_pkg::SEL_GREEN: begin
				keep = (hue.h >= scale(hwci_pkg::DEG_60, hue.d)) &&
					(hue.h <= scale(hwci_pkg::DEG_160, hue.d));
			end
			hwci_pkg::SEL_BLUE: begin
				keep = (hue.h >= scale(hwci_pkg::DEG_160, hue.d)) &&
					(hue.h <= scale(hwci_pkg::DEG_230, hue.d));
			end
			default: begin
				valid_sel = 1'b0;
			end
		endcase
	end

	always_comb begin
		if (!valid_sel) begin
			red_out   = '0;
			green_out = '0;
			blue_out  = '0;
			kept      = 1'b0;
		end else if (keep) begin
			red_out   = red;
			green_out = green;
			blue_out  = blue;
			kept      = 1'b1;
		end else begin
			red_out   = hue.mx;
			green_out = hue.mx;
			blue_out  = hue.mx;
			kept      = 1'b0;
		end
	end

endmodule

// ===== rtl/hue_window_color_isolate.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hue_window_color_isolate
// Color splash: keeps pixels whose hue lies in a selected window, greys others.
// ----------------------------------------------------------------------------
// Usage:
// Pixels enter on the s_axis stream, one item per pixel, with red in
// tdata[7:0], green in tdata[15:8] and blue in tdata[23:16]. Each pixel gives
// exactly one item on m_axis: the pixel itself when its hue falls in the
// window chosen by color_select (tuser = 1), the pixel greyed to its largest
// channel otherwise (tuser = 0), or black for an unused select code.
// The block has two register stages: an input register and a result register,
// with the hue and window test computed in between. A pixel accepted into the
// input register is loaded into the result register when that register is
// free and shows on m_axis from there. One pixel is taken in every cycle
// while the receiver keeps up, so throughput is one item per clock. When the
// receiver stalls, the result register holds its item and the input register
// still takes one more pixel if it is empty; s_axis_tready then drops until
// the result is taken. No state links pixels. Reset empties both stages and
// sets color_select to red. The user must write the select register through
// cfg_we/cfg_wdata only while the stream is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module hue_window_color_isolate (
	input  logic                          clk,
	input  logic                          arst_n,
	// Configuration: color_select
	input  logic                          cfg_we,
	input  logic [hwci_pkg::SEL_W-1:0]    cfg_wdata,
	// Input stream
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	// tdata fields from bit 0: red_in[7:0], green_in[7:0], blue_in[7:0]
	input  logic [3*hwci_pkg::CHAN_W-1:0] s_axis_tdata,
	// Output stream
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// tdata fields from bit 0: red_out[7:0], green_out[7:0], blue_out[7:0]
	output logic [3*hwci_pkg::CHAN_W-1:0] m_axis_tdata,
	// tuser fields from bit 0: kept
	output logic                          m_axis_tuser
);

	localparam int CW = hwci_pkg::CHAN_W;

	logic [hwci_pkg::SEL_W-1:0] color_select_q;

	logic          valid_s1;
	logic [CW-1:0] red_s1;
	logic [CW-1:0] green_s1;
	logic [CW-1:0] blue_s1;

	logic          valid_s2;
	logic [CW-1:0] red_s2;
	logic [CW-1:0] green_s2;
	logic [CW-1:0] blue_s2;
	logic          kept_s2;

	hwci_pkg::hue_t hue;
	logic [CW-1:0]  red_w;
	logic [CW-1:0]  green_w;
	logic [CW-1:0]  blue_w;
	logic           kept_w;

	logic s2_ready;
	logic s1_ready;
	logic in_fire;

	// The result register takes a new item when empty or being drained, and
	// the input register when empty or moving its item on.
	assign s2_ready      = !valid_s2 || m_axis_tready;
	assign s1_ready      = !valid_s1 || s2_ready;
	assign s_axis_tready = s1_ready;
	assign in_fire       = s_axis_tvalid && s1_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_select_q <= hwci_pkg::SEL_RESET;
		end else if (cfg_we) begin
			color_select_q <= cfg_wdata;
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_ready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			red_s1   <= s_axis_tdata[CW-1:0];
			green_s1 <= s_axis_tdata[2*CW-1:CW];
			blue_s1  <= s_axis_tdata[3*CW-1:2*CW];
		end
	end

	hwci_hue u_hue (
		.red   (red_s1),
		.green (green_s1),
		.blue  (blue_s1),
		.hue   (hue)
	);

	hwci_window u_window (
		.color_select (color_select_q),
		.hue          (hue),
		.red          (red_s1),
		.green        (green_s1),
		.blue         (blue_s1),
		.red_out      (red_w),
		.green_out    (green_w),
		.blue_out     (blue_w),
		.kept         (kept_w)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_ready && valid_s1) begin
			red_s2   <= red_w;
			green_s2 <= green_w;
			blue_s2  <= blue_w;
			kept_s2  <= kept_w;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {blue_s2, green_s2, red_s2};
	assign m_axis_tuser  = kept_s2;

endmodule
